[src/csvft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared codes and the result type of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // quote tracking state
  localparam logic [1:0] Q_UNQUOTED = 2'd0;
  localparam logic [1:0] Q_QUOTED   = 2'd1;
  localparam logic [1:0] Q_PENDING  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;

  // row-end error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED = 2'd1;
  localparam logic [1:0] ERR_COUNT    = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  localparam int unsigned DATA_W = 24;

  typedef struct packed {
    logic [1:0] error_code;
    logic       is_header;
    logic [6:0] field_count;
    logic [5:0] field_index;
    logic [7:0] out_byte;
    logic [1:0] kind;
  } tok_result_t;

endpackage

[src/csvft_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvft_core
// Quote/field state and the per-item result logic of the tokenizer.
// ----------------------------------------------------------------------------
module csvft_core #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  input  logic                 line_end_i,
  output logic                 res_valid_o,
  output csvft_pkg::tok_result_t res_o
);

  localparam int unsigned FW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam int unsigned CW = $clog2(MAX_FIELDS + 1);
  localparam logic [FW-1:0] LAST_IDX = FW'(MAX_FIELDS - 1);

  logic [1:0]    quote_q, quote_d;
  logic [FW-1:0] field_q, field_d;
  logic          ovf_q, ovf_d;
  logic          hdr_seen_q, hdr_seen_d;
  logic [CW-1:0] hdr_count_q, hdr_count_d;

  logic [CW-1:0] count;
  logic          as_unquoted;
  logic          emit;
  logic [1:0]    kind;
  logic [7:0]    obyte;
  logic [1:0]    err;

  assign count = CW'(field_q) + CW'(1);

  always_comb begin
    quote_d     = quote_q;
    field_d     = field_q;
    ovf_d       = ovf_q;
    hdr_seen_d  = hdr_seen_q;
    hdr_count_d = hdr_count_q;
    as_unquoted = 1'b0;
    emit        = 1'b0;
    kind        = csvft_pkg::KIND_BYTE;
    obyte       = byte_i;
    err         = csvft_pkg::ERR_OK;

    if (line_end_i) begin
      emit  = 1'b1;
      kind  = csvft_pkg::KIND_ROW_END;
      obyte = 8'd0;
      if (quote_q == csvft_pkg::Q_QUOTED) begin
        err = csvft_pkg::ERR_UNCLOSED;
      end else if (ovf_q) begin
        err = csvft_pkg::ERR_OVERFLOW;
      end else if (hdr_seen_q && (count != hdr_count_q)) begin
        err = csvft_pkg::ERR_COUNT;
      end
      if (!hdr_seen_q) begin
        hdr_seen_d  = 1'b1;
        hdr_count_d = count;
      end
      quote_d = csvft_pkg::Q_UNQUOTED;
      field_d = '0;
      ovf_d   = 1'b0;
    end else begin
      case (quote_q)
        csvft_pkg::Q_QUOTED: begin
          if (byte_i == csvft_pkg::CH_QUOTE) begin
            quote_d = csvft_pkg::Q_PENDING;
          end else begin
            emit = 1'b1;
          end
        end
        csvft_pkg::Q_PENDING: begin
          if (byte_i == csvft_pkg::CH_QUOTE) begin
            // doubled quote inside quotes: one literal quote
            quote_d = csvft_pkg::Q_QUOTED;
            emit    = 1'b1;
          end else begin
            as_unquoted = 1'b1;
          end
        end
        default: begin
          as_unquoted = 1'b1;
        end
      endcase

      if (as_unquoted) begin
        quote_d = csvft_pkg::Q_UNQUOTED;
        if (byte_i == csvft_pkg::CH_QUOTE) begin
          quote_d = csvft_pkg::Q_QUOTED;
        end else if (byte_i == csvft_pkg::CH_COMMA) begin
          emit  = 1'b1;
          kind  = csvft_pkg::KIND_FIELD_END;
          obyte = 8'd0;
          if (field_q == LAST_IDX) begin
            ovf_d = 1'b1;
          end else begin
            field_d = field_q + FW'(1);
          end
        end else begin
          emit = 1'b1;
        end
      end
    end
  end

  assign res_valid_o       = fire_i & emit;
  assign res_o.kind        = kind;
  assign res_o.out_byte    = obyte;
  assign res_o.field_index = 6'(field_q);
  assign res_o.field_count = line_end_i ? 7'(count) : 7'd0;
  assign res_o.is_header   = ~hdr_seen_q;
  assign res_o.error_code  = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q     <= csvft_pkg::Q_UNQUOTED;
      field_q     <= '0;
      ovf_q       <= 1'b0;
      hdr_seen_q  <= 1'b0;
      hdr_count_q <= '0;
    end else if (fire_i) begin
      quote_q     <= quote_d;
      field_q     <= field_d;
      ovf_q       <= ovf_d;
      hdr_seen_q  <= hdr_seen_d;
      hdr_count_q <= hdr_count_d;
    end
  end

endmodule

[src/csvft_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvft_out_stage
// Output register plus skid entry; decouples downstream stalls from input.
// ----------------------------------------------------------------------------
module csvft_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  csvft_pkg::tok_result_t data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  take_i,
  output csvft_pkg::tok_result_t data_o
);

  logic                   out_valid_q;
  logic                   skid_valid_q;
  csvft_pkg::tok_result_t out_q;
  csvft_pkg::tok_result_t skid_q;
  logic                   out_fire;

  assign out_fire = out_valid_q & take_i;
  assign ready_o  = ~skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

[src/csv_field_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Each result is registered in the output stage before the master side sees it.
// Throughput: one item per cycle; the output register and a one-entry skid
// let input continue while a result waits; ready drops only when both fill.
// Reset (rst_ni low, async): quote state unquoted, field index 0, header
// not yet seen, output side empty.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [13:8] field_index, [20:14] field_count,
  // [21] is_header, [23:22] error_code
  output logic [csvft_pkg::DATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // kind
);

  logic                   fire;
  logic                   res_valid;
  csvft_pkg::tok_result_t res;
  csvft_pkg::tok_result_t out_res;

  assign fire = s_axis_tvalid & s_axis_tready;

  csvft_core #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (s_axis_tdata),
    .line_end_i (s_axis_tlast),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  csvft_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .ready_o(s_axis_tready),
    .valid_o(m_axis_tvalid),
    .take_i (m_axis_tready),
    .data_o (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {out_res.error_code, out_res.is_header, out_res.field_count,
                         out_res.field_index, out_res.out_byte};

endmodule
